FILE: rtl/tch_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath interface types
// for the triplet cluster histogram; no dependencies
package tch_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_GENES    = 1024;
  localparam int COUNT_W      = 32;

  localparam int ACTION_W = 2;
  localparam int GENE_W   = 11;
  localparam int MASK_W   = 16;
  localparam int IDX_W    = 4;
  localparam int ACT_W    = 5;

  localparam int CL_W       = $clog2(MAX_CLUSTERS);
  localparam int GADDR_W    = $clog2(MAX_GENES);
  localparam int HIST_AW    = 3 * CL_W;
  localparam int HIST_DEPTH = MAX_CLUSTERS * MAX_CLUSTERS * MAX_CLUSTERS;
  localparam int CMP_W      = (ACT_W > CL_W + 1) ? ACT_W : CL_W + 1;

  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(16);

  localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_MEM_A,
    ST_MEM_B,
    ST_MEM_C,
    ST_SETUP,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_HIST_RD,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic mem_wr;
    logic rd_a;
    logic rd_b;
    logic rd_c;
    logic cap_ma;
    logic cap_mb;
    logic setup;
    logic walk_rd;
    logic walk_wr;
    logic hist_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic                clr_last;
    logic [ACTION_W-1:0] action;
    logic                genes_ok;
    logic                batch_end;
    logic                setup_empty;
    logic                walk_last;
    logic                out_free;
  } status_t;

endpackage

FILE: rtl/tch_ctrl.sv
`timescale 1ns / 1ps
// control state machine: clearing pass, item decode, mask fetch, combination walk,
// histogram read and response; depends on tch_pkg
module tch_ctrl import tch_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd,
  output state_t  fsm_state
);

  state_t state_r;
  state_t state_nxt;
  logic   need_result;

  assign need_result = (status.action == ACT_READ) ||
                       ((status.action == ACT_ADD) && status.batch_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (status.action)
          ACT_LOAD: state_nxt = ST_IDLE;
          ACT_ADD:  state_nxt = status.genes_ok ? ST_MEM_A : ST_RESP;
          ACT_READ: state_nxt = ST_HIST_RD;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_MEM_A:   state_nxt = ST_MEM_B;
      ST_MEM_B:   state_nxt = ST_MEM_C;
      ST_MEM_C:   state_nxt = ST_SETUP;
      ST_SETUP:   state_nxt = status.setup_empty ? ST_RESP : ST_WALK_RD;
      ST_WALK_RD: state_nxt = ST_WALK_WR;
      ST_WALK_WR: state_nxt = status.walk_last ? ST_RESP : ST_WALK_RD;
      ST_HIST_RD: state_nxt = ST_RESP;
      ST_RESP: begin
        if (!need_result || status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR:   cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECODE:  cmd.mem_wr = (status.action == ACT_LOAD);
      ST_MEM_A:   cmd.rd_a = 1'b1;
      ST_MEM_B: begin
        cmd.rd_b   = 1'b1;
        cmd.cap_ma = 1'b1;
      end
      ST_MEM_C: begin
        cmd.rd_c   = 1'b1;
        cmd.cap_mb = 1'b1;
      end
      ST_SETUP:   cmd.setup = 1'b1;
      ST_WALK_RD: cmd.walk_rd = 1'b1;
      ST_WALK_WR: cmd.walk_wr = 1'b1;
      ST_HIST_RD: cmd.hist_rd = 1'b1;
      ST_RESP:    cmd.out_load = need_result && status.out_free;
      default:    cmd = '0;
    endcase
  end

  assign fsm_state = state_r;

endmodule

FILE: rtl/tch_datapath.sv
`timescale 1ns / 1ps
// datapath: word registers, membership and histogram memories, combination walk,
// config register and output register; depends on tch_pkg
module tch_datapath import tch_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [GENE_W-1:0]   in_gene_a,
  input  logic [GENE_W-1:0]   in_gene_b,
  input  logic [GENE_W-1:0]   in_gene_c,
  input  logic [MASK_W-1:0]   in_membership_mask,
  input  logic [IDX_W-1:0]    in_read_x,
  input  logic [IDX_W-1:0]    in_read_y,
  input  logic [IDX_W-1:0]    in_read_z,
  input  logic                in_batch_end,
  input  logic                cfg_valid,
  input  logic [ACT_W-1:0]    cfg_active_clusters,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COUNT_W-1:0]  out_count_value,
  output logic                out_read_valid,
  output logic                out_batch_done
);

  typedef logic [MAX_CLUSTERS-1:0] cmask_t;

  function automatic logic gene_ok(input logic [GENE_W-1:0] g);
    return (g != '0) && (g <= GENE_W'(MAX_GENES));
  endfunction

  function automatic logic [GADDR_W-1:0] gene_addr(input logic [GENE_W-1:0] g);
    logic [GENE_W-1:0] d;
    d = g - GENE_W'(1);
    return d[GADDR_W-1:0];
  endfunction

  function automatic logic [CL_W-1:0] lowest(input cmask_t v);
    logic [CL_W-1:0] idx;
    idx = '0;
    for (int i = MAX_CLUSTERS - 1; i >= 0; i--) begin
      if (v[i]) idx = CL_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [HIST_AW-1:0] sorted_addr(input logic [CL_W-1:0] a,
                                                     input logic [CL_W-1:0] b,
                                                     input logic [CL_W-1:0] c);
    logic [CL_W-1:0] x, y, z, t;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    return {x, y, z};
  endfunction

  // captured word
  logic [ACTION_W-1:0] action_r;
  logic [GENE_W-1:0]   ga_r, gb_r, gc_r;
  logic [MASK_W-1:0]   mask_r;
  logic [IDX_W-1:0]    rx_r, ry_r, rz_r;
  logic                bend_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= in_action;
      ga_r     <= in_gene_a;
      gb_r     <= in_gene_b;
      gc_r     <= in_gene_c;
      mask_r   <= in_membership_mask;
      rx_r     <= in_read_x;
      ry_r     <= in_read_y;
      rz_r     <= in_read_z;
      bend_r   <= in_batch_end;
    end
  end

  // active cluster mask
  logic [ACT_W-1:0] act_r;
  cmask_t           act_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= ACT_RESET;
    end else if (cfg_valid) begin
      act_r <= cfg_active_clusters;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_CLUSTERS; i++) begin
      act_mask[i] = CMP_W'(i) < CMP_W'(act_r);
    end
  end

  // membership memory
  cmask_t             mem [MAX_GENES];
  cmask_t             mem_q;
  logic [GADDR_W-1:0] mem_raddr;

  always_comb begin
    mem_raddr = gene_addr(ga_r);
    if (cmd.rd_b) mem_raddr = gene_addr(gb_r);
    if (cmd.rd_c) mem_raddr = gene_addr(gc_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && gene_ok(ga_r)) mem[gene_addr(ga_r)] <= MAX_CLUSTERS'(mask_r);
    if (cmd.rd_a || cmd.rd_b || cmd.rd_c) mem_q <= mem[mem_raddr];
  end

  // combination walk
  cmask_t mq_act;
  cmask_t ma_r, mb_r, mc_r;
  cmask_t x_rem_r, y_rem_r, z_rem_r;
  cmask_t x_left, y_left, z_left;

  assign mq_act = mem_q & act_mask;
  assign x_left = x_rem_r & (x_rem_r - MAX_CLUSTERS'(1));
  assign y_left = y_rem_r & (y_rem_r - MAX_CLUSTERS'(1));
  assign z_left = z_rem_r & (z_rem_r - MAX_CLUSTERS'(1));

  always_ff @(posedge clk) begin
    if (cmd.cap_ma) ma_r <= mq_act;
    if (cmd.cap_mb) mb_r <= mq_act;
    if (cmd.setup) begin
      mc_r    <= mq_act;
      x_rem_r <= ma_r;
      y_rem_r <= mb_r;
      z_rem_r <= mq_act;
    end else if (cmd.walk_wr) begin
      if (z_left != '0) begin
        z_rem_r <= z_left;
      end else begin
        z_rem_r <= mc_r;
        if (y_left != '0) begin
          y_rem_r <= y_left;
        end else begin
          y_rem_r <= mb_r;
          x_rem_r <= x_left;
        end
      end
    end
  end

  // histogram memory
  logic [COUNT_W-1:0] hist [HIST_DEPTH];
  logic [COUNT_W-1:0] hist_q;
  logic [HIST_AW-1:0] clr_cnt_r;
  logic [HIST_AW-1:0] walk_addr_r;
  logic [HIST_AW-1:0] hist_raddr;
  logic [HIST_AW-1:0] hist_waddr;
  logic [COUNT_W-1:0] hist_wdata;

  assign hist_raddr = cmd.walk_rd ?
                      sorted_addr(lowest(x_rem_r), lowest(y_rem_r), lowest(z_rem_r)) :
                      {rx_r[CL_W-1:0], ry_r[CL_W-1:0], rz_r[CL_W-1:0]};
  assign hist_waddr = cmd.clr_wr ? clr_cnt_r : walk_addr_r;
  assign hist_wdata = cmd.clr_wr ? '0 : ((hist_q == '1) ? hist_q : hist_q + COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + HIST_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) walk_addr_r <= hist_raddr;
    if (cmd.clr_wr || cmd.walk_wr) hist[hist_waddr] <= hist_wdata;
    if (cmd.walk_rd || cmd.hist_rd) hist_q <= hist[hist_raddr];
  end

  // output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_read_r;
  logic               out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_r  <= (action_r == ACT_READ);
      out_done_r  <= (action_r == ACT_ADD);
      out_count_r <= (action_r == ACT_READ) ? hist_q : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_count_value = out_count_r;
  assign out_read_valid  = out_read_r;
  assign out_batch_done  = out_done_r;

  assign status.clr_last    = (clr_cnt_r == HIST_AW'(HIST_DEPTH - 1));
  assign status.action      = action_r;
  assign status.genes_ok    = gene_ok(ga_r) && gene_ok(gb_r) && gene_ok(gc_r);
  assign status.batch_end   = bend_r;
  assign status.setup_empty = (ma_r == '0) || (mb_r == '0) || (mq_act == '0);
  assign status.walk_last   = (x_left == '0) && (y_left == '0) && (z_left == '0);
  assign status.out_free    = !out_valid_r || out_ready;

endmodule

FILE: rtl/triplet_cluster_histogram.sv
`timescale 1ns / 1ps
// sequence: load writes the membership mask in decode; read runs decode, histogram
// read, response, out_valid registered after; add runs decode, mask reads, setup,
// one histogram read-modify-write per combination, response (decode, response on a
// bad gene index); a stalled result waits in response; one word at a time, the next
// accepted in idle; reset: synchronous active low; a clearing pass zeroes the histogram,
// in_ready low until it ends; active_clusters resets to 16
module triplet_cluster_histogram import tch_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [GENE_W-1:0]   in_gene_a,
  input  logic [GENE_W-1:0]   in_gene_b,
  input  logic [GENE_W-1:0]   in_gene_c,
  input  logic [MASK_W-1:0]   in_membership_mask,
  input  logic [IDX_W-1:0]    in_read_x,
  input  logic [IDX_W-1:0]    in_read_y,
  input  logic [IDX_W-1:0]    in_read_z,
  input  logic                in_batch_end,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ACT_W-1:0]    cfg_active_clusters,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COUNT_W-1:0]  out_count_value,
  output logic                out_read_valid,
  output logic                out_batch_done
);

  cmd_t    cmd;
  status_t status;
  state_t  fsm_state;

  assign cfg_ready = 1'b1;

  tch_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd),
    .fsm_state (fsm_state)
  );

  tch_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_action           (in_action),
    .in_gene_a           (in_gene_a),
    .in_gene_b           (in_gene_b),
    .in_gene_c           (in_gene_c),
    .in_membership_mask  (in_membership_mask),
    .in_read_x           (in_read_x),
    .in_read_y           (in_read_y),
    .in_read_z           (in_read_z),
    .in_batch_end        (in_batch_end),
    .cfg_valid           (cfg_valid),
    .cfg_active_clusters (cfg_active_clusters),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_count_value     (out_count_value),
    .out_read_valid      (out_read_valid),
    .out_batch_done      (out_batch_done)
  );

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (fsm_state == ST_DECODE))
    else $error("accepted word not decoded");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_state == ST_CLEAR) |-> !in_ready)
    else $error("word accepted during clearing pass");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_read_valid != out_batch_done))
    else $error("result is neither read nor batch done");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_batch_done) |-> (out_count_value == '0))
    else $error("batch done result carries a count");

endmodule
